// ----- sv/utc_pkg.sv -----
package utc_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned OFF_W    = 5;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned DAYS_W   = 16;  // whole days in 32 bits of seconds

  localparam logic [TS_W-1:0]    DAY_SECS    = 32'd86400;
  localparam logic [TS_W-1:0]    HOUR_SECS   = 32'd3600;
  localparam logic [TS_W-1:0]    MIN_SECS    = 32'd60;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1970;
  localparam logic [YEAR_W-1:0]  SKIP_CENT   = 12'd2100;
  localparam logic [MONTH_W-1:0] FEB         = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd11;
  localparam logic [OFF_W-1:0]   OFFSET_RST  = 5'b11101;  // -3 hours

  // gregorian rule over 1970..2106: 2000 is a leap century, 2100 is not
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != SKIP_CENT);
  endfunction

  function automatic logic [TS_W-1:0] year_days(input logic [YEAR_W-1:0] y);
    return is_leap(y) ? 32'd366 : 32'd365;
  endfunction

  function automatic logic [TS_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [TS_W-1:0] d;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 32'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    d = 32'd30;
      FEB:                                        d = leap ? 32'd29 : 32'd28;
      default:                                    d = 32'd31;
    endcase
    return d;
  endfunction

  // negated offset in seconds, so that a - b gives timestamp + offset
  function automatic logic [TS_W-1:0] offset_neg_secs(input logic [OFF_W-1:0] off);
    logic signed [TS_W-1:0] ext;
    logic signed [TS_W-1:0] prod;
    ext  = $signed({{(TS_W-OFF_W){off[OFF_W-1]}}, off});
    prod = ext * 32'sd3600;
    return TS_W'(-prod);
  endfunction

endpackage

// ----- sv/utc_in_if.sv -----
interface utc_in_if;
  import utc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp;
  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

// ----- sv/utc_out_if.sv -----
interface utc_out_if;
  import utc_pkg::*;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

// ----- sv/unix_time_to_calendar.sv -----
// channel  dir  fields                                       transfer when
// in_i     in   timestamp                                    valid & ready
// out_o    out  year month day_of_month hour minute second   valid & ready
// cfg      in   utc_offset_hours (cfg_wdata_i)               cfg_we_i
//
// one item runs through one offset add, 16 + 5 + 6 restoring division steps,
// up to 137 year steps and up to 12 month steps, all through a single 32-bit
// subtract/compare unit, and then a load of the result into the output register.
// in_i.ready is high only while the sequencer is idle.
// the result sits in an output register, so the next transfer on in_i is
// taken while out_o still stalls; a new result waits until that slot frees.
// reset clears the sequencer, output valid and sets the offset to -3 hours.
module unix_time_to_calendar
  import utc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [OFF_W-1:0] cfg_wdata_i,
  utc_in_if.sink           in_i,
  utc_out_if.source        out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_DDIV = 3'd2;
  localparam logic [2:0] ST_HDIV = 3'd3;
  localparam logic [2:0] ST_MDIV = 3'd4;
  localparam logic [2:0] ST_YEAR = 3'd5;
  localparam logic [2:0] ST_MON  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam logic [3:0] DDIV_TOP = 4'(DAYS_W - 1);
  localparam logic [3:0] HDIV_TOP = 4'(HOUR_W - 1);
  localparam logic [3:0] MDIV_TOP = 4'(MIN_W - 1);

  // control
  logic [2:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [OFF_W-1:0] off_q;

  // datapath
  logic [TS_W-1:0]    rem_q, rem_d;
  logic [DAYS_W-1:0]  days_q, days_d;
  logic [HOUR_W-1:0]  hour_q, hour_d;
  logic [MIN_W-1:0]   min_q, min_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [MONTH_W-1:0] month_q, month_d;

  // output register
  logic [YEAR_W-1:0]  oyear_q, oyear_d;
  logic [MONTH_W-1:0] omonth_q, omonth_d;
  logic [DAY_W-1:0]   oday_q, oday_d;
  logic [HOUR_W-1:0]  ohour_q, ohour_d;
  logic [MIN_W-1:0]   omin_q, omin_d;
  logic [SEC_W-1:0]   osec_q, osec_d;

  // shared unit
  logic [TS_W-1:0] sub_b;
  logic [TS_W-1:0] sub_diff;
  logic            sub_ge;

  logic in_xfer;
  logic out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // subtrahend per phase: shifted divisors for division, lengths for the loops
  always_comb begin
    case (state_q)
      ST_ADD:  sub_b = offset_neg_secs(off_q);
      ST_DDIV: sub_b = DAY_SECS << cnt_q;
      ST_HDIV: sub_b = HOUR_SECS << cnt_q;
      ST_MDIV: sub_b = MIN_SECS << cnt_q;
      ST_YEAR: sub_b = year_days(year_q);
      ST_MON:  sub_b = month_days(month_q, is_leap(year_q));
      default: sub_b = '0;
    endcase
  end

  utc_subu u_subu (
    .a_i    (rem_q),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    days_d      = days_q;
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    year_d      = year_q;
    month_d     = month_q;
    oyear_d     = oyear_q;
    omonth_d    = omonth_q;
    oday_d      = oday_q;
    ohour_d     = ohour_q;
    omin_d      = omin_q;
    osec_d      = osec_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rem_d   = in_i.timestamp;
          days_d  = '0;
          hour_d  = '0;
          min_d   = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        // wraps modulo 2^32
        rem_d   = sub_diff;
        cnt_d   = DDIV_TOP;
        state_d = ST_DDIV;
      end
      ST_DDIV: begin
        if (sub_ge) rem_d = sub_diff;
        days_d = {days_q[DAYS_W-2:0], sub_ge};
        if (cnt_q == '0) begin
          cnt_d   = HDIV_TOP;
          state_d = ST_HDIV;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_HDIV: begin
        if (sub_ge) rem_d = sub_diff;
        hour_d = {hour_q[HOUR_W-2:0], sub_ge};
        if (cnt_q == '0) begin
          cnt_d   = MDIV_TOP;
          state_d = ST_MDIV;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_MDIV: begin
        min_d = {min_q[MIN_W-2:0], sub_ge};
        if (cnt_q == '0) begin
          // what is left is the second; day count moves into the accumulator
          sec_d   = sub_ge ? sub_diff[SEC_W-1:0] : rem_q[SEC_W-1:0];
          rem_d   = {{(TS_W-DAYS_W){1'b0}}, days_q};
          year_d  = EPOCH_YEAR;
          state_d = ST_YEAR;
        end else begin
          if (sub_ge) rem_d = sub_diff;
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_YEAR: begin
        if (sub_ge) begin
          rem_d  = sub_diff;
          year_d = year_q + 12'd1;
        end else begin
          month_d = '0;
          state_d = ST_MON;
        end
      end
      ST_MON: begin
        if (sub_ge && (month_q != LAST_MONTH)) begin
          rem_d   = sub_diff;
          month_d = month_q + 4'd1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          oyear_d     = year_q;
          omonth_d    = month_q + 4'd1;
          oday_d      = rem_q[DAY_W-1:0] + 5'd1;
          ohour_d     = hour_q;
          omin_d      = min_q;
          osec_d      = sec_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      off_q       <= OFFSET_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) off_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    days_q   <= days_d;
    hour_q   <= hour_d;
    min_q    <= min_d;
    sec_q    <= sec_d;
    year_q   <= year_d;
    month_q  <= month_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
    ohour_q  <= ohour_d;
    omin_q   <= omin_d;
    osec_q   <= osec_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.year         = oyear_q;
  assign out_o.month        = omonth_q;
  assign out_o.day_of_month = oday_q;
  assign out_o.hour         = ohour_q;
  assign out_o.minute       = omin_q;
  assign out_o.second       = osec_q;

`ifndef NO_ASSERTIONS
  // an input transfer always starts the offset add
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_ADD))
    else $error("input transfer did not start conversion");

  // the month walk never passes december
  a_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MON) |-> (month_q <= LAST_MONTH))
    else $error("month index out of range");

  // a result is loaded only into a free output slot
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_valid_q && !out_o.ready) |=> (state_q == ST_FIN))
    else $error("result overwrote a pending transfer");
`endif

endmodule

// ----- sv/utc_subu.sv -----
module utc_subu
  import utc_pkg::*;
(
  input  logic [TS_W-1:0] a_i,
  input  logic [TS_W-1:0] b_i,
  output logic [TS_W-1:0] diff_o,
  output logic            ge_o
);

  logic [TS_W:0] full;

  // borrow out clear means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[TS_W-1:0];
  assign ge_o   = ~full[TS_W];

endmodule
